// ===== rtl/sacl_pkg.sv =====
// shared constants and row types of the set-associative tag and replacement store
package sacl_pkg;
  localparam int unsigned SETS = 64;
  localparam int unsigned WAYS = 4;
  localparam int unsigned TAG_BITS = 20;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned IN_SET_BITS = 6;
  localparam int unsigned IN_TAG_BITS = 20;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [WAY_BITS-1:0] AgeReset = WAY_BITS'(WAYS - 1);

  typedef struct packed {
    logic                  valid;
    logic [TAG_BITS-1:0]   tag;
    logic [WAY_BITS-1:0]   age;
    logic [COUNT_BITS-1:0] count;
  } line_t;

  typedef struct packed {
    line_t [WAYS-1:0]    lines;
    logic [WAY_BITS-1:0] victim;
  } row_t;

  typedef struct packed {
    logic                hit;
    logic [WAY_BITS-1:0] way;
    logic                evicted;
    logic [TAG_BITS-1:0] evicted_tag;
  } result_t;

  localparam int unsigned ROW_BITS = $bits(row_t);

  function automatic row_t row_reset();
    row_t r;
    for (int i = 0; i < WAYS; i++) begin
      r.lines[i].valid = 1'b0;
      r.lines[i].tag = '0;
      r.lines[i].age = AgeReset;
      r.lines[i].count = '0;
    end
    r.victim = '0;
    return r;
  endfunction
endpackage

// ===== rtl/sacl_row_ram.sv =====
// set row memory, one write and one registered read port
module sacl_row_ram import sacl_pkg::*; (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [SET_BITS-1:0] waddr_i,
  input  row_t                wdata_i,
  input  logic [SET_BITS-1:0] raddr_i,
  output row_t                rdata_o
);
  row_t mem [SETS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/sacl_update.sv =====
// hit detection, victim choice and age and count update of one set row
module sacl_update import sacl_pkg::*; (
  input  row_t                row_i,
  input  logic [TAG_BITS-1:0] tag_i,
  input  logic                policy_i,
  output row_t                row_o,
  output result_t             res_o
);
  always_comb begin
    row_t r;
    logic found, empty;
    logic [WAY_BITS-1:0] w, fw, ew, lw, h, vp;
    r = row_i;
    found = 1'b0; empty = 1'b0;
    fw = '0; ew = '0; lw = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (row_i.lines[i].valid && row_i.lines[i].tag == tag_i) begin
        found = 1'b1; fw = WAY_BITS'(i);
      end
      if (!row_i.lines[i].valid) begin
        empty = 1'b1; ew = WAY_BITS'(i);
      end
    end
    for (int i = 1; i < WAYS; i++) begin
      if (row_i.lines[i].count < row_i.lines[lw].count) lw = WAY_BITS'(i);
    end
    res_o = '0;
    if (found) begin
      w = fw;
      vp = row_i.victim;
      res_o.hit = 1'b1;
    end else begin
      if (empty) w = ew;
      else begin
        w = policy_i ? lw : row_i.victim;
        res_o.evicted = 1'b1;
        res_o.evicted_tag = row_i.lines[w].tag;
      end
      r.lines[w].valid = 1'b1;
      r.lines[w].tag = tag_i;
      vp = '0;
    end
    res_o.way = w;
    if (r.lines[w].count != CountMax) r.lines[w].count = r.lines[w].count + 1'b1;
    h = r.lines[w].age;
    r.lines[w].age = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_BITS'(i) != w && r.lines[i].valid) begin
        if (r.lines[i].age < h) r.lines[i].age = r.lines[i].age + 1'b1;
        if (r.lines[vp].age < r.lines[i].age) vp = WAY_BITS'(i);
      end
    end
    r.victim = vp;
    row_o = r;
  end
endmodule

// ===== rtl/set_assoc_cache_lru_lfu.sv =====
// top level of the set-associative tag and replacement store
// the set row is read into the row memory output register when a word is accepted,
// and the result word is then registered in the output slot
// the row memory read-modify-write loop lets no new word in until its row is written back
// reset: a clearing pass writes every set row, one per cycle;
// no input word is accepted until it ends; the policy register resets to lru
module set_assoc_cache_lru_lfu import sacl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // set_index[5:0], tag[25:6], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // way[1:0], evicted[2], evicted_tag[22:3], zero fill
  output logic        m_axis_tuser,  // hit
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);
  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ} state_e;

  state_e state_q;
  logic [SET_BITS:0] clr_q;
  logic policy_q;
  logic [SET_BITS-1:0] set_q;
  logic [TAG_BITS-1:0] tag_q;
  logic out_valid_q;
  result_t out_q;
  row_t rd_row, new_row, wr_row;
  result_t res;
  logic we;
  logic [SET_BITS-1:0] waddr, raddr;
  logic [IN_SET_BITS-1:0] in_set;
  logic [IN_TAG_BITS-1:0] in_tag;

  assign in_set = s_axis_tdata[IN_SET_BITS-1:0];
  assign in_tag = s_axis_tdata[IN_SET_BITS +: IN_TAG_BITS];

  // accept only when idle and the output slot is free or draining
  assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);

  // set index wraps modulo sets; tag upper bits dropped
  assign raddr = SET_BITS'(in_set % SETS);

  sacl_row_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_row),
    .raddr_i (raddr),
    .rdata_o (rd_row)
  );

  sacl_update u_upd (
    .row_i    (rd_row),
    .tag_i    (tag_q),
    .policy_i (policy_q),
    .row_o    (new_row),
    .res_o    (res)
  );

  always_comb begin
    if (state_q == ST_CLEAR) begin
      we = 1'b1;
      waddr = clr_q[SET_BITS-1:0];
      wr_row = row_reset();
    end else begin
      we = (state_q == ST_READ);
      waddr = set_q;
      wr_row = new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      policy_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) policy_q <= cfg_wdata_i;
      // new result word takes the slot, otherwise it empties once taken
      if (state_q == ST_READ) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (SET_BITS+1)'(SETS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      set_q <= raddr;
      tag_q <= TAG_BITS'(in_tag);
    end
    if (state_q == ST_READ) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser = out_q.hit;
  assign m_axis_tdata = {1'b0, out_q.evicted_tag, out_q.evicted, out_q.way};

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready) else $error("accept during clear");
  a_read_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == ST_READ) else $error("no read");
  a_result_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> m_axis_tvalid) else $error("result lost");
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[2]) else $error("hit evicted");
endmodule

// ===== tb/set_assoc_cache_lru_lfu_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the set-associative tag store with lru and lfu replacement
module set_assoc_cache_lru_lfu_tb;
  import sacl_pkg::*;

  localparam int unsigned WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [IN_SET_BITS-1:0] set_idx;
    logic [IN_TAG_BITS-1:0] tag;
  } access_t;

  typedef struct {
    logic                hit;
    logic [WAY_BITS-1:0] way;
    logic                evicted;
    logic [TAG_BITS-1:0] ev_tag;
  } lookup_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;

  set_assoc_cache_lru_lfu u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_wdata_i
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // shadow copy of the tag store
  logic                  shd_valid [SETS][WAYS];
  logic [TAG_BITS-1:0]   shd_tag   [SETS][WAYS];
  logic [WAY_BITS-1:0]   shd_age   [SETS][WAYS];
  logic [COUNT_BITS-1:0] shd_count [SETS][WAYS];
  logic [WAY_BITS-1:0]   shd_victim[SETS];
  logic                  shd_lfu;

  access_t access_q[$];
  lookup_t lookup_q[$];
  int      n_errors = 0;
  int      n_checked = 0;
  int      n_hits = 0;
  int      n_evicts = 0;
  int      src_idle_pct = 0;
  int      snk_stall_pct = 0;
  int      wdog = 0;

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  // w becomes youngest, younger valid lines age, victim pointer tracks the oldest
  function automatic void touch_way(int s, int w);
    logic [WAY_BITS-1:0] h;
    h = shd_age[s][w];
    shd_age[s][w] = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (i != w && shd_valid[s][i]) begin
        if (shd_age[s][i] < h) shd_age[s][i]++;
        if (shd_age[s][shd_victim[s]] < shd_age[s][i]) shd_victim[s] = WAY_BITS'(i);
      end
    end
  endfunction

  function automatic lookup_t predict_lookup(access_t a);
    lookup_t r;
    int s, w;
    logic found, empty;
    s = a.set_idx % SETS;
    r = '{default: '0};
    found = 1'b0;
    empty = 1'b0;
    w = 0;
    for (int i = 0; i < WAYS; i++)
      if (!found && shd_valid[s][i] && shd_tag[s][i] == a.tag[TAG_BITS-1:0]) begin
        found = 1'b1;
        w = i;
      end
    if (found) begin
      r.hit = 1'b1;
      shd_count[s][w] = sat_inc(shd_count[s][w]);
      touch_way(s, w);
    end else begin
      for (int i = 0; i < WAYS; i++)
        if (!empty && !shd_valid[s][i]) begin
          empty = 1'b1;
          w = i;
        end
      if (!empty) begin
        if (!shd_lfu) w = shd_victim[s];
        else begin
          w = 0;
          for (int i = 1; i < WAYS; i++) if (shd_count[s][i] < shd_count[s][w]) w = i;
        end
        r.evicted = 1'b1;
        r.ev_tag = shd_tag[s][w];
      end
      shd_valid[s][w] = 1'b1;
      shd_tag[s][w] = a.tag[TAG_BITS-1:0];
      shd_count[s][w] = sat_inc(shd_count[s][w]);
      shd_victim[s] = '0;
      touch_way(s, w);
    end
    r.way = WAY_BITS'(w);
    return r;
  endfunction

  // driver, set index in the low bits of the word and the tag above it
  always @(posedge clk_i) begin
    access_t a;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid)
          lookup_q.push_back(predict_lookup(
            access_t'({s_axis_tdata[5:0], s_axis_tdata[25:6]})));
        if (access_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          a = access_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'b0, a.tag, a.set_idx};
        end else s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    lookup_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (lookup_q.size() == 0) begin
        $display("%0t: unexpected result word %h hit %b", $time, m_axis_tdata, m_axis_tuser);
        n_errors++;
      end else begin
        e = lookup_q.pop_front();
        n_checked++;
        n_hits += e.hit;
        n_evicts += e.evicted;
        if (m_axis_tuser !== e.hit || m_axis_tdata[1:0] !== e.way ||
            m_axis_tdata[2] !== e.evicted || m_axis_tdata[22:3] !== e.ev_tag ||
            m_axis_tdata[23] !== 1'b0) begin
          $display("%0t: mismatch exp hit %b way %0d ev %b tag %h, got hit %b word %h",
                   $time, e.hit, e.way, e.evicted, e.ev_tag, m_axis_tuser, m_axis_tdata);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) wdog <= 0;
    else if (access_q.size() > 0 || lookup_q.size() > 0 || s_axis_tvalid) wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("watchdog expired with %0d results pending", lookup_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic drain();
    while (access_q.size() > 0 || s_axis_tvalid || lookup_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_policy(logic lfu);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lfu;
    shd_lfu = lfu;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly reuse of a small tag pool, mostly in sets 0 to 3, so hits and evictions are common
  task automatic queue_random(int n);
    access_t a;
    for (int k = 0; k < n; k++) begin
      a.set_idx = (($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(3)));
      if ($urandom_range(9) < 8) a.tag = {$urandom_range(1) ? 17'h1ffff : 17'h0,
                                          3'($urandom_range(6))};
      else a.tag = 20'($urandom);
      access_q.push_back(a);
    end
  endtask

  initial begin
    for (int s = 0; s < SETS; s++) begin
      shd_victim[s] = '0;
      for (int w = 0; w < WAYS; w++) begin
        shd_valid[s][w] = 1'b0;
        shd_tag[s][w] = '0;
        shd_age[s][w] = AgeReset;
        shd_count[s][w] = '0;
      end
    end
    shd_lfu = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: fill a set, hit, evict by lru, extreme set and tag values
    for (int t = 0; t < 6; t++) access_q.push_back('{6'd0, 20'(t)});
    access_q.push_back('{6'd0, 20'd5});
    access_q.push_back('{6'd0, 20'd2});
    access_q.push_back('{6'd0, 20'd9});
    for (int t = 0; t < 5; t++) access_q.push_back('{6'd63, t[0] ? 20'hfffff : 20'h0});
    access_q.push_back('{6'd63, 20'h12345});
    access_q.push_back('{6'd63, 20'h54321});
    access_q.push_back('{6'd63, 20'habcde});
    drain();

    // directed lfu: heavily used lines survive
    set_policy(1'b1);
    for (int t = 0; t < 6; t++) access_q.push_back('{6'd0, 20'd2});
    access_q.push_back('{6'd0, 20'h77777});
    access_q.push_back('{6'd0, 20'h88888});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_policy(ph[0]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 22; snk_stall_pct = 22; end
      endcase
      queue_random(100);
      drain();
    end

    $display("checked %0d lookups, %0d hits, %0d evictions, both policies, all stall mixes",
             n_checked, n_hits, n_evicts);
    if (n_errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
